// ----- hdl/oef3_pkg.sv -----
// shared types and constants of the three-axis one-euro filter
package oef3_pkg;

    localparam int AXES        = 3;
    localparam int AXIS_W      = $clog2(AXES);
    localparam int SAMPLE_BITS = 32;
    localparam int FRAC_BITS   = 16;
    localparam int TS_BITS     = 64;
    localparam int ALPHA_BITS  = 30;
    localparam int DIV_STEPS   = ALPHA_BITS / 2;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int CUTOFF_BITS = 26;
    localparam int GAIN_BITS   = 22;
    localparam int CFG_BITS    = 26;
    localparam int IN_BITS     = TS_BITS + AXES * SAMPLE_BITS;
    localparam int OUT_BITS    = AXES * SAMPLE_BITS;

    localparam logic [63:0] TAU_SCALE = 64'd10430378350470;
    localparam logic [63:0] P_LIMIT   = 64'h2000_0000_0000_0000;

    localparam logic [1:0] REG_MIN_CUTOFF   = 2'd0;
    localparam logic [1:0] REG_SPEED_GAIN   = 2'd1;
    localparam logic [1:0] REG_DELTA_CUTOFF = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SEED,
        OP_DT,
        OP_PMUL,
        OP_NORM,
        OP_DIV,
        OP_KEEPD,
        OP_DDIFF,
        OP_YDIFF,
        OP_MUL,
        OP_DAPPLY,
        OP_YAPPLY,
        OP_FC,
        OP_OUT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_DT,
        ST_PMUL,
        ST_NORM,
        ST_DIV,
        ST_KEEPD,
        ST_DDIFF,
        ST_DMUL,
        ST_DAPPLY,
        ST_FC,
        ST_YDIFF,
        ST_YMUL,
        ST_YAPPLY,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t              op;
        logic [AXIS_W-1:0]   axis;
        logic                use_fc;
    } dp_cmd_t;

    typedef struct packed {
        logic seeded;
    } dp_status_t;

endpackage

// ----- hdl/oef3_dp.sv -----
// datapath: state, shared multiplier paths and radix-4 alpha divider
module oef3_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  oef3_pkg::dp_cmd_t               cmd,
    output oef3_pkg::dp_status_t            status,
    input  logic [oef3_pkg::IN_BITS-1:0]    in_data,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [oef3_pkg::CFG_BITS-1:0]   cfg_data,
    output logic [oef3_pkg::OUT_BITS-1:0]   out_data,
    output logic                            out_flag
);

    localparam int SB = oef3_pkg::SAMPLE_BITS;

    logic [oef3_pkg::CUTOFF_BITS-1:0] min_cut_reg;
    logic [oef3_pkg::GAIN_BITS-1:0]   gain_reg;
    logic [oef3_pkg::CUTOFF_BITS-1:0] dcut_reg;

    logic                seeded_reg;
    logic [63:0]         last_time_reg;
    logic [63:0]         ts_reg;
    logic [SB-1:0]       y_reg  [oef3_pkg::AXES];
    logic [SB-1:0]       lo_reg [oef3_pkg::AXES];
    logic [SB-1:0]       sd_reg [oef3_pkg::AXES];
    logic [31:0]         dt_reg;
    logic [31:0]         fc_reg;
    logic [63:0]         p_reg;
    logic [63:0]         rem_reg;
    logic [63:0]         s_reg;
    logic [oef3_pkg::ALPHA_BITS-1:0] q_reg;
    logic [oef3_pkg::ALPHA_BITS-1:0] alpha_d_reg;
    logic [SB:0]         mag_reg;
    logic                neg_reg;
    logic [SB:0]         adj_reg;
    logic [oef3_pkg::OUT_BITS-1:0] out_data_reg;
    logic                out_flag_reg;
    logic                pass_reg;

    logic [63:0]   ts_diff;
    logic [31:0]   mul_a;
    logic [63:0]   p_next;
    logic [63:0]   p_shift;
    logic [63:0]   d_shift;
    logic [63:0]   r1;
    logic [63:0]   r1b;
    logic [63:0]   r2;
    logic [63:0]   r2b;
    logic          b1;
    logic          b2;
    logic [SB-1:0] y_sel;
    logic [SB-1:0] lo_sel;
    logic [SB-1:0] sd_sel;
    logic [SB:0]   dy_wide;
    logic [SB-1:0] dy_sat;
    logic [SB-1:0] op_a;
    logic [SB-1:0] op_b;
    logic [SB:0]   diff;
    logic [oef3_pkg::ALPHA_BITS-1:0] alpha_sel;
    logic [62:0]   adj_prod;
    logic [SB-1:0] prev_sel;
    logic [SB:0]   applied;
    logic [SB-1:0] amag;
    logic [53:0]   gain_prod;
    logic [38:0]   fc_sum;

    assign ts_diff   = ts_reg - last_time_reg;
    assign y_sel     = y_reg[cmd.axis];
    assign lo_sel    = lo_reg[cmd.axis];
    assign sd_sel    = sd_reg[cmd.axis];
    assign mul_a     = cmd.use_fc ? fc_reg : {6'd0, dcut_reg};
    assign p_next    = {32'd0, mul_a} * {32'd0, dt_reg};

    always_comb
    begin
        priority if ((p_reg >> 2) > oef3_pkg::P_LIMIT)
        begin
            p_shift = p_reg >> 3;
            d_shift = oef3_pkg::TAU_SCALE >> 3;
        end
        else if ((p_reg >> 1) > oef3_pkg::P_LIMIT)
        begin
            p_shift = p_reg >> 2;
            d_shift = oef3_pkg::TAU_SCALE >> 2;
        end
        else if (p_reg > oef3_pkg::P_LIMIT)
        begin
            p_shift = p_reg >> 1;
            d_shift = oef3_pkg::TAU_SCALE >> 1;
        end
        else
        begin
            p_shift = p_reg;
            d_shift = oef3_pkg::TAU_SCALE;
        end
    end

    // two quotient bits per cycle
    assign r1  = rem_reg << 1;
    assign b1  = (r1 >= s_reg);
    assign r1b = b1 ? r1 - s_reg : r1;
    assign r2  = r1b << 1;
    assign b2  = (r2 >= s_reg);
    assign r2b = b2 ? r2 - s_reg : r2;

    assign dy_wide = {y_sel[SB-1], y_sel} - {lo_sel[SB-1], lo_sel};
    always_comb
    begin
        if (dy_wide[SB] != dy_wide[SB-1])
            dy_sat = dy_wide[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        else
            dy_sat = dy_wide[SB-1:0];
    end

    assign op_a = (cmd.op == oef3_pkg::OP_DDIFF) ? dy_sat : y_sel;
    assign op_b = (cmd.op == oef3_pkg::OP_DDIFF) ? sd_sel : lo_sel;
    assign diff = {op_a[SB-1], op_a} - {op_b[SB-1], op_b};

    assign alpha_sel = cmd.use_fc ? q_reg : alpha_d_reg;
    assign adj_prod  = {{(62-SB){1'b0}}, mag_reg} * {33'd0, alpha_sel}
                     + (63'd1 << (oef3_pkg::ALPHA_BITS - 1));

    assign prev_sel = (cmd.op == oef3_pkg::OP_DAPPLY) ? sd_sel : lo_sel;
    assign applied  = neg_reg ? {prev_sel[SB-1], prev_sel} - adj_reg
                              : {prev_sel[SB-1], prev_sel} + adj_reg;

    assign amag      = sd_sel[SB-1] ? (~sd_sel + 1'b1) : sd_sel;
    assign gain_prod = {32'd0, gain_reg} * {22'd0, amag};
    assign fc_sum    = {1'b0, gain_prod[53:oef3_pkg::FRAC_BITS]}
                     + {13'd0, min_cut_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_cut_reg   <= 26'd1966080;
            gain_reg      <= 22'd39322;
            dcut_reg      <= 26'd1638400;
            seeded_reg    <= 1'b0;
            last_time_reg <= '0;
            for (int i = 0; i < oef3_pkg::AXES; i++)
            begin
                lo_reg[i] <= '0;
                sd_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    oef3_pkg::REG_MIN_CUTOFF:   min_cut_reg <= cfg_data;
                    oef3_pkg::REG_SPEED_GAIN:   gain_reg <= cfg_data[oef3_pkg::GAIN_BITS-1:0];
                    oef3_pkg::REG_DELTA_CUTOFF: dcut_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (cmd.op)
                oef3_pkg::OP_SEED:
                begin
                    seeded_reg    <= 1'b1;
                    last_time_reg <= ts_reg;
                    for (int i = 0; i < oef3_pkg::AXES; i++)
                    begin
                        lo_reg[i] <= y_reg[i];
                        sd_reg[i] <= '0;
                    end
                end
                oef3_pkg::OP_DT:     last_time_reg <= ts_reg;
                oef3_pkg::OP_DAPPLY: sd_reg[cmd.axis] <= applied[SB-1:0];
                oef3_pkg::OP_YAPPLY: lo_reg[cmd.axis] <= applied[SB-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            oef3_pkg::OP_LOAD:
            begin
                ts_reg <= in_data[oef3_pkg::TS_BITS-1:0];
                for (int i = 0; i < oef3_pkg::AXES; i++)
                    y_reg[i] <= in_data[oef3_pkg::TS_BITS + i*SB +: SB];
            end
            oef3_pkg::OP_SEED: pass_reg <= 1'b1;
            oef3_pkg::OP_DT:
            begin
                dt_reg   <= (|ts_diff[63:32]) ? 32'hFFFF_FFFF : ts_diff[31:0];
                pass_reg <= 1'b0;
            end
            oef3_pkg::OP_PMUL: p_reg <= p_next;
            oef3_pkg::OP_NORM:
            begin
                rem_reg <= p_shift;
                s_reg   <= p_shift + d_shift;
                q_reg   <= '0;
            end
            oef3_pkg::OP_DIV:
            begin
                rem_reg <= r2b;
                q_reg   <= {q_reg[oef3_pkg::ALPHA_BITS-3:0], b1, b2};
            end
            oef3_pkg::OP_KEEPD: alpha_d_reg <= q_reg;
            oef3_pkg::OP_DDIFF, oef3_pkg::OP_YDIFF:
            begin
                neg_reg <= diff[SB];
                mag_reg <= diff[SB] ? (~diff + 1'b1) : diff;
            end
            oef3_pkg::OP_MUL: adj_reg <= adj_prod[62:oef3_pkg::ALPHA_BITS];
            oef3_pkg::OP_FC:  fc_reg <= (|fc_sum[38:32]) ? 32'hFFFF_FFFF : fc_sum[31:0];
            oef3_pkg::OP_OUT:
            begin
                for (int i = 0; i < oef3_pkg::AXES; i++)
                    out_data_reg[i*SB +: SB] <= lo_reg[i];
                out_flag_reg <= pass_reg;
            end
            default: ;
        endcase
    end

    assign status.seeded = seeded_reg;
    assign out_data      = out_data_reg;
    assign out_flag      = out_flag_reg;

endmodule

// ----- hdl/oef3_ctrl.sv -----
// controller: sequences the datapath and owns the handshakes
module oef3_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  oef3_pkg::dp_status_t  status,
    output oef3_pkg::dp_cmd_t     cmd
);

    oef3_pkg::ctrl_state_t state_reg;
    oef3_pkg::ctrl_state_t state_next;
    logic [oef3_pkg::AXIS_W-1:0] axis_reg;
    logic [oef3_pkg::AXIS_W-1:0] axis_next;
    logic [oef3_pkg::STEP_W-1:0] step_reg;
    logic [oef3_pkg::STEP_W-1:0] step_next;
    logic phase_reg;
    logic phase_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;
    logic last_step;
    logic last_axis;

    assign out_free  = !out_valid_reg || out_ready;
    assign last_step = (step_reg == oef3_pkg::STEP_W'(oef3_pkg::DIV_STEPS - 1));
    assign last_axis = (axis_reg == oef3_pkg::AXIS_W'(oef3_pkg::AXES - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            oef3_pkg::ST_IDLE:
                if (in_valid)
                    state_next = status.seeded ? oef3_pkg::ST_DT : oef3_pkg::ST_SEED;
            oef3_pkg::ST_SEED:   state_next = oef3_pkg::ST_DONE;
            oef3_pkg::ST_DT:     state_next = oef3_pkg::ST_PMUL;
            oef3_pkg::ST_PMUL:   state_next = oef3_pkg::ST_NORM;
            oef3_pkg::ST_NORM:   state_next = oef3_pkg::ST_DIV;
            oef3_pkg::ST_DIV:
                if (last_step)
                    state_next = phase_reg ? oef3_pkg::ST_YDIFF : oef3_pkg::ST_KEEPD;
            oef3_pkg::ST_KEEPD:  state_next = oef3_pkg::ST_DDIFF;
            oef3_pkg::ST_DDIFF:  state_next = oef3_pkg::ST_DMUL;
            oef3_pkg::ST_DMUL:   state_next = oef3_pkg::ST_DAPPLY;
            oef3_pkg::ST_DAPPLY: state_next = oef3_pkg::ST_FC;
            oef3_pkg::ST_FC:     state_next = oef3_pkg::ST_PMUL;
            oef3_pkg::ST_YDIFF:  state_next = oef3_pkg::ST_YMUL;
            oef3_pkg::ST_YMUL:   state_next = oef3_pkg::ST_YAPPLY;
            oef3_pkg::ST_YAPPLY:
                state_next = last_axis ? oef3_pkg::ST_DONE : oef3_pkg::ST_DDIFF;
            oef3_pkg::ST_DONE:
                if (out_free)
                    state_next = oef3_pkg::ST_IDLE;
            default: state_next = oef3_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op         = oef3_pkg::OP_NONE;
        cmd.axis       = axis_reg;
        cmd.use_fc     = phase_reg;
        in_ready       = 1'b0;
        axis_next      = axis_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            oef3_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = oef3_pkg::OP_LOAD;
            end
            oef3_pkg::ST_SEED: cmd.op = oef3_pkg::OP_SEED;
            oef3_pkg::ST_DT:
            begin
                cmd.op     = oef3_pkg::OP_DT;
                phase_next = 1'b0;
                axis_next  = '0;
            end
            oef3_pkg::ST_PMUL: cmd.op = oef3_pkg::OP_PMUL;
            oef3_pkg::ST_NORM:
            begin
                cmd.op    = oef3_pkg::OP_NORM;
                step_next = '0;
            end
            oef3_pkg::ST_DIV:
            begin
                cmd.op    = oef3_pkg::OP_DIV;
                step_next = step_reg + 1'b1;
            end
            oef3_pkg::ST_KEEPD: cmd.op = oef3_pkg::OP_KEEPD;
            oef3_pkg::ST_DDIFF: cmd.op = oef3_pkg::OP_DDIFF;
            oef3_pkg::ST_DMUL:
            begin
                cmd.op     = oef3_pkg::OP_MUL;
                cmd.use_fc = 1'b0;
            end
            oef3_pkg::ST_DAPPLY: cmd.op = oef3_pkg::OP_DAPPLY;
            oef3_pkg::ST_FC:
            begin
                cmd.op     = oef3_pkg::OP_FC;
                phase_next = 1'b1;
            end
            oef3_pkg::ST_YDIFF: cmd.op = oef3_pkg::OP_YDIFF;
            oef3_pkg::ST_YMUL:
            begin
                cmd.op     = oef3_pkg::OP_MUL;
                cmd.use_fc = 1'b1;
            end
            oef3_pkg::ST_YAPPLY:
            begin
                cmd.op     = oef3_pkg::OP_YAPPLY;
                phase_next = 1'b0;
                if (!last_axis)
                    axis_next = axis_reg + 1'b1;
            end
            oef3_pkg::ST_DONE:
                if (out_free)
                begin
                    cmd.op         = oef3_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oef3_pkg::ST_IDLE;
            axis_reg      <= '0;
            step_reg      <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/one_euro_filter_3axis.sv -----
// top level of the three-axis one-euro filter
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: timestamp_ns, sample_x/y/z
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: filtered_x/y/z, tuser: passed_through
// cfg       in   cfg_we                         cfg_index, cfg_data
//
// a seeding item only seeds the state; later items run the time-step, divider and filter steps
// each cutoff factor is computed in the shared two-bit-per-cycle divider,
// four per item (difference cutoff once, then one per axis)
// the output register holds a result while the next item is taken in
// reset clears all filter state and restores the register defaults
module one_euro_filter_3axis
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [oef3_pkg::IN_BITS-1:0]    s_axis_tdata,   // timestamp_ns, sample_x, sample_y, sample_z
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [oef3_pkg::OUT_BITS-1:0]   m_axis_tdata,   // filtered_x, filtered_y, filtered_z
    output logic                            m_axis_tuser,   // passed_through
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [oef3_pkg::CFG_BITS-1:0]   cfg_data
);

    oef3_pkg::dp_cmd_t    cmd;
    oef3_pkg::dp_status_t status;

    oef3_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    oef3_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_axis_tdata),
        .out_flag  (m_axis_tuser)
    );

endmodule

// ----- hdl/oef3_chk.sv -----
// port checker for the three-axis one-euro filter, bound to the top level
module oef3_chk
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [oef3_pkg::OUT_BITS-1:0]   m_axis_tdata,
    input logic                            m_axis_tuser
);

    // one item at a time: intake closes right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("intake still open after accept");

    // a result never appears in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result too early");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind one_euro_filter_3axis oef3_chk u_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/tb_one_euro_filter_3axis.sv -----
// testbench of the three-axis one-euro filter: predicted results against the block's stream
`timescale 1ns / 1ps

module tb_one_euro_filter_3axis;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int HOLD_CYCLES  = 600;

    typedef struct {
        logic [oef3_pkg::SAMPLE_BITS-1:0] fx, fy, fz;
        logic                             passed;
    } filt_res_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [oef3_pkg::IN_BITS-1:0]    s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [oef3_pkg::OUT_BITS-1:0]   m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            cfg_we;
    logic [1:0]                      cfg_index;
    logic [oef3_pkg::CFG_BITS-1:0]   cfg_data;

    one_euro_filter_3axis dut (.*);

    // predictor state
    logic [63:0]  cut_min, gain, cut_delta;
    bit           was_seeded;
    logic [63:0]  prev_ts;
    longint       prev_out [oef3_pkg::AXES];
    longint       dsmooth [oef3_pkg::AXES];

    filt_res_t    expected_q[$];
    int           errors, n_items, n_results, n_seeds, cycles;
    int           send_idle_pct, recv_idle_pct;
    bit           hold_recv;
    logic [63:0]  ts_now;

    initial
    begin
        clk = 0;
        forever
        begin
            #6 clk = 1;
            #6 clk = 0;
        end
    end

    function automatic longint sx32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic logic [63:0] cutoff_factor(logic [63:0] fc, logic [63:0] dt);
        logic [63:0] p, d, s, rem, q;
        p = fc * dt;
        d = oef3_pkg::TAU_SCALE;
        q = 0;
        while (p > oef3_pkg::P_LIMIT)
        begin
            p = p >> 1;
            d = d >> 1;
        end
        s = p + d;
        rem = p;
        for (int i = 0; i < oef3_pkg::ALPHA_BITS; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= s)
            begin
                rem = rem - s;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint lowpass(logic [63:0] a, longint y, longint prev);
        longint diff;
        logic [63:0] mag, adj;
        diff = y - prev;
        mag = diff < 0 ? -diff : diff;
        adj = (mag >> oef3_pkg::ALPHA_BITS) * a
            + (((mag & 64'h3FFF_FFFF) * a + (64'd1 << (oef3_pkg::ALPHA_BITS - 1)))
               >> oef3_pkg::ALPHA_BITS);
        return diff < 0 ? prev - longint'(adj) : prev + longint'(adj);
    endfunction

    function automatic filt_res_t predict_filter(logic [oef3_pkg::IN_BITS-1:0] d);
        filt_res_t   r;
        logic [63:0] ts, dt, ad, amag, fc, a;
        longint      y [oef3_pkg::AXES];
        longint      dy;
        longint      smax;
        smax = (longint'(1) << (oef3_pkg::SAMPLE_BITS - 1)) - 1;
        ts = d[63:0];
        for (int i = 0; i < oef3_pkg::AXES; i++)
            y[i] = sx32(d[64 + 32*i +: 32]);
        if (!was_seeded)
        begin
            was_seeded = 1;
            prev_ts = ts;
            for (int i = 0; i < oef3_pkg::AXES; i++)
            begin
                prev_out[i] = y[i];
                dsmooth[i] = 0;
            end
            r.passed = 1;
        end
        else
        begin
            dt = ts - prev_ts;
            if (dt > 64'hFFFF_FFFF)
                dt = 64'hFFFF_FFFF;
            prev_ts = ts;
            ad = cutoff_factor(cut_delta, dt);
            for (int i = 0; i < oef3_pkg::AXES; i++)
            begin
                dy = y[i] - prev_out[i];
                if (dy > smax)
                    dy = smax;
                if (dy < -smax - 1)
                    dy = -smax - 1;
                dsmooth[i] = lowpass(ad, dy, dsmooth[i]);
                amag = dsmooth[i] < 0 ? -dsmooth[i] : dsmooth[i];
                fc = cut_min + gain * (amag >> oef3_pkg::FRAC_BITS)
                   + ((gain * (amag & 64'hFFFF)) >> oef3_pkg::FRAC_BITS);
                if (fc > 64'hFFFF_FFFF)
                    fc = 64'hFFFF_FFFF;
                a = cutoff_factor(fc, dt);
                prev_out[i] = lowpass(a, y[i], prev_out[i]);
            end
            r.passed = 0;
        end
        r.fx = prev_out[0][31:0];
        r.fy = prev_out[1][31:0];
        r.fz = prev_out[2][31:0];
        return r;
    endfunction

    task automatic send_sample(logic [63:0] ts, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata <= {z, y, x, ts};
        s_axis_tvalid <= 1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_q.push_back(predict_filter({z, y, x, ts}));
        n_items++;
        @(negedge clk);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [oef3_pkg::CFG_BITS-1:0] val);
        stop_sending();
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        case (idx)
            oef3_pkg::REG_MIN_CUTOFF:   cut_min = val;
            oef3_pkg::REG_SPEED_GAIN:   gain = val[oef3_pkg::GAIN_BITS-1:0];
            oef3_pkg::REG_DELTA_CUTOFF: cut_delta = val;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rnd_sample();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(4000)) - 2000) <<< 8;
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [63:0] rnd_step();
        case ($urandom_range(9))
            0: return 0;
            1: return {$urandom(), $urandom()};
            2: return $urandom();
            default: return $urandom_range(2000000, 100000);
        endcase
    endfunction

    task automatic test_directed();
        send_sample(64'd1000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        ts_now = 1000;
        send_sample(ts_now, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        ts_now = 64'hFFFF_FFFF_FFFF_FF00;
        send_sample(ts_now, 32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0000);
        ts_now = ts_now + 64'h200;
        send_sample(ts_now, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_0000);
        send_sample(64'd5, 32'h0, 32'h7FFF_FFFF, 32'h8000_0001);
        ts_now = 5;
        for (int i = 0; i < 10; i++)
        begin
            ts_now += 1000000;
            send_sample(ts_now, 32'h0010_0000 * i, -32'sh0008_0000 * i, 32'h5555_AAAA ^ i);
        end
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            ts_now += rnd_step();
            send_sample(ts_now, rnd_sample(), rnd_sample(), rnd_sample());
        end
    endtask

    task automatic test_config_sweep();
        write_reg(oef3_pkg::REG_MIN_CUTOFF, 0);
        write_reg(oef3_pkg::REG_SPEED_GAIN, 22'h3F_FFFF);
        write_reg(oef3_pkg::REG_DELTA_CUTOFF, 26'h3FF_FFFF);
        test_random(150);
        write_reg(oef3_pkg::REG_MIN_CUTOFF, 26'h3FF_FFFF);
        write_reg(oef3_pkg::REG_SPEED_GAIN, 0);
        write_reg(oef3_pkg::REG_DELTA_CUTOFF, 0);
        test_random(150);
        write_reg(2'd3, 26'h155_5555);
        write_reg(oef3_pkg::REG_SPEED_GAIN, 26'h3FF_FFFF);
        write_reg(oef3_pkg::REG_MIN_CUTOFF, 26'd65536);
        write_reg(oef3_pkg::REG_DELTA_CUTOFF, 26'd655360);
        test_random(150);
    endtask

    task automatic test_backpressure();
        hold_recv = 1;
        test_random(6);
        while (hold_recv)
            @(negedge clk);
    endtask

    // receiver: ready pattern and result checking
    always @(negedge clk)
        if (rst_n)
            m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);

    // long receiver hold, released after a fixed count
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_recv)
            begin
                stall++;
                if (stall >= HOLD_CYCLES)
                begin
                    hold_recv = 0;
                    stall = 0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        filt_res_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected item %h", $realtime, m_axis_tdata);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                n_results++;
                if (e.passed)
                    n_seeds++;
                if ({e.fz, e.fy, e.fx} !== m_axis_tdata || e.passed !== m_axis_tuser)
                begin
                    $display("%0t: mismatch expected %h/%b actual %h/%b", $realtime,
                             {e.fz, e.fy, e.fx}, e.passed, m_axis_tdata, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout with %0d results pending", expected_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        hold_recv = 0;
        cut_min = 1966080;
        gain = 39322;
        cut_delta = 1638400;
        was_seeded = 0;
        prev_ts = 0;
        for (int i = 0; i < oef3_pkg::AXES; i++)
        begin
            prev_out[i] = 0;
            dsmooth[i] = 0;
        end
        send_idle_pct = 30;
        recv_idle_pct = 50;
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_directed();
        test_random(400);
        test_backpressure();
        send_idle_pct = 50;
        recv_idle_pct = 30;
        test_config_sweep();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(500);
        test_backpressure();
        test_random(373);
        stop_sending();
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        $display("sent %0d items, checked %0d results (%0d seeding) over %0d cycles",
                 n_items, n_results, n_seeds, cycles);
        $display("covered field extremes, timestamp wrap and repeats, register sweeps");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/oef3_pkg.sv
hdl/oef3_dp.sv
hdl/oef3_ctrl.sv
hdl/one_euro_filter_3axis.sv
hdl/oef3_chk.sv
tb/tb_one_euro_filter_3axis.sv
